// ===== hdl/trl_pkg.sv =====
// shared types and constants for the talkgroup route lookup
package trl_pkg;

  localparam int unsigned ROUTES_DEF = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned TG_W       = 32;
  localparam int unsigned BCD_W      = 40;
  localparam int unsigned DIGITS     = 10;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned KIND_W     = 2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EXACT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PREFIX = 2'd2;
  // spare encoding, never matches
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the transaction fields, clear trackers
    logic wr_en;     // store one table entry
    logic conv_en;   // one double-dabble step
    logic scan_en;   // issue one table read
    logic respond;   // load the result registers
  } trl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_last;
    logic scan_last;
  } trl_status_t;

endpackage

// ===== hdl/trl_ctrl.sv =====
// controller state machine for the route lookup
module trl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 action_i,
  input  trl_pkg::trl_status_t status_i,
  output trl_pkg::trl_cmd_t    cmd_o,
  output logic                 busy
);
  import trl_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (action_i == ACT_WRITE) begin
            cmd_o.wr_en = 1'b1;
            state_d     = ST_RESP;
          end else begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cmd_o.conv_en = 1'b1;
        if (status_i.conv_last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_RESP;
      ST_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== hdl/trl_dpath.sv =====
// datapath: route table, decimal conversion and match trackers
module trl_dpath #(
  parameter int unsigned ROUTES = trl_pkg::ROUTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  trl_pkg::trl_cmd_t             cmd_i,
  output trl_pkg::trl_status_t          status_o,
  input  logic                          action_i,
  input  logic [trl_pkg::IDX_W-1:0]     entry_index_i,
  input  logic                          entry_valid_i,
  input  logic [trl_pkg::KIND_W-1:0]    entry_kind_i,
  input  logic [trl_pkg::TG_W-1:0]      range_first_i,
  input  logic [trl_pkg::TG_W-1:0]      range_last_i,
  input  logic [trl_pkg::BCD_W-1:0]     prefix_digits_i,
  input  logic [trl_pkg::LEN_W-1:0]     prefix_length_i,
  input  logic [trl_pkg::TG_W-1:0]      talkgroup_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [trl_pkg::IDX_W-1:0]     route_index_o,
  output logic [trl_pkg::KIND_W-1:0]    match_kind_o
);
  import trl_pkg::*;

  // only slots reachable by a 6-bit index are stored
  localparam int unsigned DEPTH  = (ROUTES < (1 << IDX_W)) ? ROUTES : (1 << IDX_W);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENT_W  = KIND_W + 2 * TG_W + BCD_W + LEN_W;
  localparam int unsigned CNT_W  = $clog2(TG_W);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TG_W-1:0]   low;
    logic [TG_W-1:0]   high;
    logic [BCD_W-1:0]  pfx;
    logic [LEN_W-1:0]  plen;
  } entry_t;

  logic [ENT_W-1:0] mem [DEPTH];
  entry_t           rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_vld_q;
  logic [ADDR_W-1:0] rd_idx_q, addr_q;

  logic             is_write_q;
  logic [TG_W-1:0]  tg_q, bin_q;
  logic [BCD_W-1:0] bcd_q, bcd_adj;
  logic [CNT_W-1:0] conv_cnt_q;

  logic              ex_have_q, rg_have_q, px_have_q;
  logic [ADDR_W-1:0] ex_idx_q, rg_idx_q, px_idx_q;
  logic [TG_W-1:0]   rg_span_q;
  logic [LEN_W-1:0]  px_len_q;

  logic wr_ok;
  assign wr_ok = (32'(entry_index_i) < ROUTES);

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[entry_index_i[ADDR_W-1:0]] <= {entry_kind_i, range_first_i, range_last_i,
                                         prefix_digits_i, prefix_length_i};
    end
    if (cmd_i.scan_en) rd_q <= entry_t'(mem[addr_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.wr_en && wr_ok) begin
      valid_q[entry_index_i[ADDR_W-1:0]] <= entry_valid_i;
    end
  end

  // double dabble, one bit a step
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      is_write_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_en;
      if (cmd_i.load) begin
        conv_cnt_q <= '0;
        addr_q     <= '0;
        is_write_q <= (action_i == ACT_WRITE);
      end else begin
        if (cmd_i.conv_en) conv_cnt_q <= conv_cnt_q + 1'b1;
        if (cmd_i.scan_en) addr_q <= addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tg_q  <= talkgroup_i;
      bin_q <= talkgroup_i;
      bcd_q <= '0;
    end else if (cmd_i.conv_en) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[TG_W-1]};
      bin_q <= {bin_q[TG_W-2:0], 1'b0};
    end
    if (cmd_i.scan_en) rd_idx_q <= addr_q;
  end

  assign status_o.conv_last = (conv_cnt_q == CNT_W'(TG_W - 1));
  assign status_o.scan_last = (addr_q == ADDR_W'(DEPTH - 1));

  // digit count and left-aligned digits
  logic [LEN_W-1:0] ndig;
  logic [BCD_W-1:0] dig;
  always_comb begin
    ndig = LEN_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) ndig = LEN_W'(i + 1);
    end
    dig = bcd_q << (4 * (DIGITS - 32'(ndig)));
  end

  // per-entry evaluation
  logic       act, hit_ex, hit_rg, hit_px, pfx_eq;
  logic [TG_W-1:0] span;
  always_comb begin
    act    = rd_vld_q && valid_q[rd_idx_q];
    hit_ex = act && (rd_q.kind == KIND_EXACT) && (rd_q.low == tg_q);
    hit_rg = act && (rd_q.kind == KIND_RANGE) && (tg_q >= rd_q.low) && (tg_q <= rd_q.high);
    span   = rd_q.high - rd_q.low;
    pfx_eq = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if ((32'(rd_q.plen) > i) &&
          (rd_q.pfx[BCD_W-4-4*i +: 4] != dig[BCD_W-4-4*i +: 4])) pfx_eq = 1'b0;
    end
    hit_px = act && (rd_q.kind == KIND_PREFIX) && (rd_q.plen != '0) &&
             (rd_q.plen <= ndig) && pfx_eq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_have_q <= 1'b0;
      rg_have_q <= 1'b0;
      px_have_q <= 1'b0;
    end else if (cmd_i.load) begin
      ex_have_q <= 1'b0;
      rg_have_q <= 1'b0;
      px_have_q <= 1'b0;
    end else begin
      if (hit_ex && !ex_have_q) ex_have_q <= 1'b1;
      if (hit_rg) rg_have_q <= 1'b1;
      if (hit_px) px_have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_ex && !ex_have_q) ex_idx_q <= rd_idx_q;
    if (hit_rg && (!rg_have_q || span < rg_span_q)) begin
      rg_idx_q  <= rd_idx_q;
      rg_span_q <= span;
    end
    if (hit_px && (!px_have_q || rd_q.plen > px_len_q)) begin
      px_idx_q <= rd_idx_q;
      px_len_q <= rd_q.plen;
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o        <= 1'b0;
      found_o       <= 1'b0;
      route_index_o <= '0;
      match_kind_o  <= '0;
    end else begin
      done_o <= cmd_i.respond;
      if (cmd_i.respond) begin
        found_o       <= 1'b0;
        route_index_o <= '0;
        match_kind_o  <= KIND_EXACT;
        if (!is_write_q) begin
          if (ex_have_q) begin
            found_o       <= 1'b1;
            route_index_o <= IDX_W'(ex_idx_q);
            match_kind_o  <= KIND_EXACT;
          end else if (rg_have_q) begin
            found_o       <= 1'b1;
            route_index_o <= IDX_W'(rg_idx_q);
            match_kind_o  <= KIND_RANGE;
          end else if (px_have_q) begin
            found_o       <= 1'b1;
            route_index_o <= IDX_W'(px_idx_q);
            match_kind_o  <= KIND_PREFIX;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/talkgroup_route_lookup.sv =====
// top level of the talkgroup route lookup
//
//  channel   direction  handshake            payload
//  request   in         start / busy         action_i, entry_*, range_*, prefix_*, talkgroup_i
//  result    out        done_o strobe        found_o, route_index_o, match_kind_o
//
// a write transaction stores its entry when accepted and answers from the response state
// a lookup converts the talkgroup to decimal digits by double dabble, then reads each slot
// in turn through the single table read port, then drains the last read and responds
// reset clears all slot valid bits at once, no clearing pass
// the receiver cannot stall; the done_o strobe is high for one cycle
module talkgroup_route_lookup #(
  parameter int unsigned ROUTES = trl_pkg::ROUTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [trl_pkg::IDX_W-1:0]     entry_index_i,
  input  logic                          entry_valid_i,
  input  logic [trl_pkg::KIND_W-1:0]    entry_kind_i,
  input  logic [trl_pkg::TG_W-1:0]      range_first_i,
  input  logic [trl_pkg::TG_W-1:0]      range_last_i,
  input  logic [trl_pkg::BCD_W-1:0]     prefix_digits_i,
  input  logic [trl_pkg::LEN_W-1:0]     prefix_length_i,
  input  logic [trl_pkg::TG_W-1:0]      talkgroup_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [trl_pkg::IDX_W-1:0]     route_index_o,
  output logic [trl_pkg::KIND_W-1:0]    match_kind_o
);
  import trl_pkg::*;

  trl_cmd_t    cmd;
  trl_status_t status;
  logic        ctrl_start;

  assign ctrl_start = start && !busy;

  trl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (ctrl_start),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  trl_dpath #(.ROUTES(ROUTES)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (action_i),
    .entry_index_i   (entry_index_i),
    .entry_valid_i   (entry_valid_i),
    .entry_kind_i    (entry_kind_i),
    .range_first_i   (range_first_i),
    .range_last_i    (range_last_i),
    .prefix_digits_i (prefix_digits_i),
    .prefix_length_i (prefix_length_i),
    .talkgroup_i     (talkgroup_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .route_index_o   (route_index_o),
    .match_kind_o    (match_kind_o)
  );

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accepting a transaction");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (route_index_o == '0 && match_kind_o == KIND_EXACT))
    else $error("miss result carries non-zero fields");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without a transaction in flight");

endmodule
